// ----- rtl/gle_pkg.sv -----
// Shared types, constants and helpers of the grid local extremum detector.
`timescale 1ns / 1ps
package gle_pkg;

    localparam int MAX_WINDOW  = 7;
    localparam int MAX_COLUMNS = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int COL_BITS    = 10;
    localparam int ROW_BITS    = 16;
    localparam int SLOT_BITS   = 3;
    localparam int CFG_BITS    = 16;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] REG_MODE        = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_WINDOW_ROWS = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_WINDOW_COLS = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_GRID_COLS   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_GRID_ROWS   = 3'd4;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef t_value [MAX_WINDOW-1:0] t_column;
    typedef logic [SLOT_BITS-1:0] t_slot;

    typedef struct packed {
        logic le;
        logic ge;
    } t_cell_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CENTRE,
        ST_COMPARE,
        ST_DECIDE,
        ST_EMIT_MIN,
        ST_EMIT_MAX
    } t_state;

    // Sum of two slot numbers modulo the line count, for operands below 8.
    function automatic t_slot slot_add(input logic [SLOT_BITS:0] a, input logic [SLOT_BITS:0] b);
        logic [SLOT_BITS+1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_BITS+2)'(MAX_WINDOW)) begin
            s = s - (SLOT_BITS+2)'(MAX_WINDOW);
        end
        if (s >= (SLOT_BITS+2)'(MAX_WINDOW)) begin
            s = s - (SLOT_BITS+2)'(MAX_WINDOW);
        end
        return s[SLOT_BITS-1:0];
    endfunction

endpackage

// ----- rtl/gle_line_store.sv -----
// Line store: one memory bank per buffered grid row, read one column at a time.
`timescale 1ns / 1ps
module gle_line_store (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  gle_pkg::t_slot         i_wr_slot,
    input  logic [gle_pkg::COL_BITS-1:0] i_addr,
    input  gle_pkg::t_value        i_wdata,
    output gle_pkg::t_column       o_rdata
);
    import gle_pkg::*;

    for (genvar s = 0; s < MAX_WINDOW; s++) begin : g_bank
        t_value mem [MAX_COLUMNS];
        t_value r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we && (i_wr_slot == SLOT_BITS'(s))) begin
                mem[i_addr] <= i_wdata;
            end
            r_rd <= mem[i_addr];
        end

        assign o_rdata[s] = r_rd;
    end

endmodule

// ----- rtl/gle_cell.sv -----
// Window cell: holds one window column by line slot and compares it with the centre.
`timescale 1ns / 1ps
module gle_cell (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic                  i_cmp,
    input  gle_pkg::t_column      i_col,
    input  gle_pkg::t_value       i_centre,
    input  logic [gle_pkg::MAX_WINDOW-1:0] i_mask,
    input  logic                  i_active,
    input  logic                  i_centre_here,
    input  gle_pkg::t_slot        i_centre_slot,
    output gle_pkg::t_column      o_col,
    output gle_pkg::t_cell_flags  o_flags
);
    import gle_pkg::*;

    t_column     r_col;
    t_cell_flags r_flags;
    t_cell_flags n_flags;

    always_comb begin
        n_flags = '0;
        for (int s = 0; s < MAX_WINDOW; s++) begin
            if (i_active && i_mask[s] &&
                !(i_centre_here && (i_centre_slot == SLOT_BITS'(s)))) begin
                if ($signed(r_col[s]) <= $signed(i_centre)) n_flags.le = 1'b1;
                if ($signed(r_col[s]) >= $signed(i_centre)) n_flags.ge = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
        if (i_cmp) begin
            r_flags <= n_flags;
        end
    end

    assign o_col   = r_col;
    assign o_flags = r_flags;

endmodule

// ----- rtl/grid_local_extremum_detector.sv -----
// Top level of the grid local extremum detector.
`timescale 1ns / 1ps
// Samples arrive in raster order, one per input beat, and each sample occupies the block
// until done: a line store read on acceptance, a column chain shift, centre selection,
// a compare in every cell and a final reduction. The first result beat is shown in the
// cycle after the reduction; each result beat, at most two per sample, is held while the
// output stalls, and the next sample is taken in the cycle after the last result beat
// has left, or after the reduction if none is sent. The line store keeps seven grid rows
// of up to 1024 columns in seven banks, and a row of seven cells holds the last seven
// columns of the window. The window centre sits at offset (rows/2, cols/2); when it is
// strictly below all other window samples a minimum beat is sent, when strictly above a
// maximum beat, the minimum first, and last marks the final beat of a sample.
// Configuration must be written only while idle; the block itself does not enforce this.
// Line store entries never written read as arbitrary data, and a window that covers
// them after a mid-frame window change gives undefined results.
module grid_local_extremum_detector (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [31:0]     i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [15:0]            o_point_row,
    output logic [9:0]             o_point_col,
    output logic signed [31:0]     o_point_value,
    output logic                   o_is_high,
    output logic                   o_last,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data
);
    import gle_pkg::*;

    // Configuration registers.
    logic [1:0]  r_mode;
    logic [2:0]  r_win_rows;
    logic [2:0]  r_win_cols;
    logic [10:0] r_grid_cols;
    logic [15:0] r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 2'd3;
            r_win_rows  <= 3'd3;
            r_win_cols  <= 3'd3;
            r_grid_cols <= 11'd1024;
            r_grid_rows <= 16'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:        r_mode      <= i_cfg_data[1:0];
                REG_WINDOW_ROWS: r_win_rows  <= i_cfg_data[2:0];
                REG_WINDOW_COLS: r_win_cols  <= i_cfg_data[2:0];
                REG_GRID_COLS:   r_grid_cols <= i_cfg_data[10:0];
                REG_GRID_ROWS:   r_grid_rows <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: a zero size counts as one and the column count saturates.
    logic [2:0]  wr;
    logic [2:0]  wc;
    logic [10:0] gc;
    logic [15:0] gr;

    assign wr = (r_win_rows == 3'd0) ? 3'd1 : r_win_rows;
    assign wc = (r_win_cols == 3'd0) ? 3'd1 : r_win_cols;
    assign gc = (r_grid_cols == 11'd0) ? 11'd1 :
                ((r_grid_cols > 11'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS) : r_grid_cols);
    assign gr = (r_grid_rows == 16'd0) ? 16'd1 : r_grid_rows;

    // Control state.
    t_state r_state;
    t_state n_state;
    logic   in_beat;

    assign in_beat  = i_valid && (r_state == ST_IDLE);

    // Raster position of the next sample, and its line slot (row modulo seven).
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;
    t_slot               r_slot;

    // Position of the sample being taken now, after wrapping on a smaller grid.
    logic [COL_BITS-1:0] a_col;
    logic [ROW_BITS:0]   a_row;
    t_slot               a_slot;
    logic [COL_BITS:0]   p_col;
    logic [ROW_BITS:0]   p_row;
    t_slot               p_slot;

    always_comb begin
        a_col  = r_col;
        a_row  = {1'b0, r_row};
        a_slot = r_slot;
        if ({1'b0, r_col} >= gc) begin
            a_col  = '0;
            a_row  = a_row + 1'b1;
            a_slot = slot_add({1'b0, r_slot}, 4'd1);
        end
        if (a_row >= {1'b0, gr}) begin
            a_row  = '0;
            a_slot = '0;
        end
        p_col  = {1'b0, a_col} + 1'b1;
        p_row  = a_row;
        p_slot = a_slot;
        if (p_col >= gc) begin
            p_col  = '0;
            p_row  = a_row + 1'b1;
            p_slot = slot_add({1'b0, a_slot}, 4'd1);
            if (p_row >= {1'b0, gr}) begin
                p_row  = '0;
                p_slot = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (in_beat) begin
            r_col  <= p_col[COL_BITS-1:0];
            r_row  <= p_row[ROW_BITS-1:0];
            r_slot <= p_slot;
        end
    end

    // The sample in flight and where it lies.
    logic [COL_BITS-1:0] r_cur_col;
    logic [ROW_BITS-1:0] r_cur_row;
    t_slot               r_cur_slot;
    t_value              r_sample;

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cur_col  <= a_col;
            r_cur_row  <= a_row[ROW_BITS-1:0];
            r_cur_slot <= a_slot;
            r_sample   <= i_sample;
        end
    end

    // Line store: the sample is written and its column read at the same edge.
    t_column rd_col;
    t_column load_col;

    gle_line_store u_store (
        .i_clk     (i_clk),
        .i_we      (in_beat),
        .i_wr_slot (a_slot),
        .i_addr    (a_col),
        .i_wdata   (i_sample),
        .o_rdata   (rd_col)
    );

    // The current row's slot still holds old data in the read, so the sample replaces it.
    always_comb begin
        load_col = rd_col;
        load_col[r_cur_slot] = r_sample;
    end

    // Window geometry in line slots and cells. Cell j holds column col - j.
    t_slot                 top_slot;
    t_slot                 centre_slot;
    logic [2:0]            centre_cell;
    logic [MAX_WINDOW-1:0] slot_mask;

    always_comb begin
        top_slot = slot_add({1'b0, r_cur_slot}, 4'd8 - {1'b0, wr});
        centre_slot = slot_add({1'b0, top_slot}, {2'b0, wr[2:1]});
        centre_cell = wc - 3'd1 - {1'b0, wc[2:1]};
        slot_mask = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (i < int'(wr)) begin
                slot_mask[slot_add({1'b0, top_slot}, 4'(i))] = 1'b1;
            end
        end
    end

    // Chain of window cells.
    t_column     cell_col   [MAX_WINDOW];
    t_cell_flags cell_flags [MAX_WINDOW];
    t_value      r_centre;

    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
        gle_cell u_cell (
            .i_clk         (i_clk),
            .i_shift       (r_state == ST_LOAD),
            .i_cmp         (r_state == ST_COMPARE),
            .i_col         ((j == 0) ? load_col : cell_col[(j == 0) ? 0 : j - 1]),
            .i_centre      (r_centre),
            .i_mask        (slot_mask),
            .i_active      (3'(j) < wc),
            .i_centre_here (centre_cell == 3'(j)),
            .i_centre_slot (centre_slot),
            .o_col         (cell_col[j]),
            .o_flags       (cell_flags[j])
        );
    end

    // Centre selection, window check and result fields.
    logic                r_win_ok;
    logic [ROW_BITS-1:0] r_prow;
    logic [COL_BITS-1:0] r_pcol;
    logic                r_max;
    logic                any_le;
    logic                any_ge;

    always_comb begin
        any_le = 1'b0;
        any_ge = 1'b0;
        for (int j = 0; j < MAX_WINDOW; j++) begin
            any_le = any_le | cell_flags[j].le;
            any_ge = any_ge | cell_flags[j].ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CENTRE) begin
            r_centre <= cell_col[centre_cell][centre_slot];
            r_win_ok <= (r_mode != 2'd0) &&
                        ({1'b0, r_cur_row} + 17'd1 >= {14'd0, wr}) &&
                        ({1'b0, r_cur_col} + 11'd1 >= {8'd0, wc});
            r_prow   <= r_cur_row - {13'd0, wr} + 16'd1 + {14'd0, wr[2:1]};
            r_pcol   <= r_cur_col - {7'd0, wc} + 10'd1 + {8'd0, wc[2:1]};
        end
        if (r_state == ST_DECIDE) begin
            r_max <= r_win_ok && r_mode[1] && !any_ge;
        end
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_LOAD;
            ST_LOAD:     n_state = ST_CENTRE;
            ST_CENTRE:   n_state = ST_COMPARE;
            ST_COMPARE:  n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_win_ok && r_mode[0] && !any_le) begin
                    n_state = ST_EMIT_MIN;
                end else if (r_win_ok && r_mode[1] && !any_ge) begin
                    n_state = ST_EMIT_MAX;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_MIN: if (!i_stall) n_state = r_max ? ST_EMIT_MAX : ST_IDLE;
            ST_EMIT_MAX: if (!i_stall) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: outputs.
    always_comb begin
        o_stall   = (r_state != ST_IDLE);
        o_valid   = (r_state == ST_EMIT_MIN) || (r_state == ST_EMIT_MAX);
        o_is_high = (r_state == ST_EMIT_MAX);
        o_last    = (r_state == ST_EMIT_MAX) || !r_max;
    end

    assign o_point_row   = r_prow;
    assign o_point_col   = r_pcol;
    assign o_point_value = r_centre;

endmodule

// ----- rtl/gle_checker.sv -----
// Port-level checks of the grid local extremum detector, bound to the top level.
`timescale 1ns / 1ps
module gle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_point_row,
    input logic [9:0]  o_point_col,
    input logic [31:0] o_point_value,
    input logic        o_is_high,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_value) && $stable(o_is_high)
            && $stable(o_point_row) && $stable(o_point_col))
        else $error("stalled result beat changed");

    a_max_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_high |-> o_last)
        else $error("maximum beat not marked last");

    a_min_then_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && o_is_high)
        else $error("minimum beat not followed by its maximum");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result beat is pending");

endmodule

bind grid_local_extremum_detector gle_checker u_gle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_point_row   (o_point_row),
    .o_point_col   (o_point_col),
    .o_point_value (o_point_value),
    .o_is_high     (o_is_high),
    .o_last        (o_last)
);
